FILE: rtl/t3cr_pkg.sv
// Package for the Type 3 tag Check response checker: codes, frame offsets, result type.
package t3cr_pkg;

    localparam int unsigned RxW      = 8;
    localparam int unsigned PosW     = 9;
    localparam int unsigned IdW      = 64;
    localparam int unsigned OutDataW = 32;

    // Check command is 0x06, its response code is one more
    localparam logic [RxW-1:0] CmdCheck     = 8'h06;
    localparam logic [RxW-1:0] RespCode     = CmdCheck + 8'h01;
    localparam logic [PosW-1:0] HeaderLen   = 9'd12;  // length, code, 8 id bytes, 2 flags
    localparam logic [PosW-1:0] PayloadPos  = 9'd13;
    localparam logic [PosW-1:0] PosMax      = 9'd256;
    localparam logic [PosW-1:0] IdFirstPos  = 9'd2;
    localparam logic [PosW-1:0] IdLastPos   = 9'd9;
    localparam logic [PosW-1:0] Flag1Pos    = 9'd10;
    localparam logic [PosW-1:0] Flag2Pos    = 9'd11;
    localparam logic [PosW-1:0] LenPos      = 9'd0;
    localparam logic [PosW-1:0] CodePos     = 9'd1;

    typedef enum logic [2:0] {
        VERDICT_OK         = 3'd0,
        VERDICT_TOO_SHORT  = 3'd1,
        VERDICT_LEN_MISM   = 3'd2,
        VERDICT_BAD_CODE   = 3'd3,
        VERDICT_ID_MISM    = 3'd4,
        VERDICT_CARD_ERROR = 3'd5
    } t_verdict;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_VERDICT = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind          kind;
        logic [RxW-1:0] payload;
        t_verdict       verdict;
        logic [RxW-1:0] flag1;
        logic [RxW-1:0] flag2;
        logic           last;
    } t_result;

endpackage

FILE: rtl/tag3_check_response_checker.sv
// Type 3 tag Check response checker: byte-wise header check, payload pass-through, verdict.
// Results are registered in the result queue and offered on the master side from its head.
// Throughput: one request per cycle; a frame whose last byte is payload yields two results,
// which drain from a four-entry result queue at one per cycle while m_axis_tready is high.
// The slave side stalls only while the queue holds over two results (output backpressure).
// Reset (i_rst_n low, synchronous): frame state cleared, queue emptied, identifier set to 0.
module tag3_check_response_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration: expected card identifier, first received byte in bits 63:56
    input  logic                              i_cfg_wr_en,
    input  logic [t3cr_pkg::IdW-1:0]          i_cfg_wr_data,
    // slave side: received bytes
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [t3cr_pkg::RxW-1:0]          s_axis_tdata,   // [7:0] rx_byte
    input  logic                              s_axis_tlast,   // frame_end
    // master side: results
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] payload_byte, [10:8] verdict, [18:11] first_status_flag,
    // [26:19] second_status_flag, [31:27] zero
    output logic [t3cr_pkg::OutDataW-1:0]     m_axis_tdata,
    output logic                              m_axis_tuser,   // result_kind
    output logic                              m_axis_tlast    // run_last
);
    import t3cr_pkg::*;

    localparam int unsigned QDepth = 4;
    localparam int unsigned QPtrW  = $clog2(QDepth);
    localparam int unsigned QCntW  = QPtrW + 1;
    localparam int unsigned PadW   = OutDataW - (3 * RxW + 3);

    // ---- frame state ----
    logic [IdW-1:0]  r_card_id;
    logic [PosW-1:0] r_pos,   n_pos;
    logic [RxW-1:0]  r_len,   n_len;
    logic            r_code_ok, n_code_ok;
    logic            r_id_ok,   n_id_ok;
    logic [RxW-1:0]  r_flag1, n_flag1;
    logic [RxW-1:0]  r_flag2, n_flag2;

    // ---- result queue ----
    t_result           r_queue [QDepth];
    logic [QPtrW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPtrW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCntW-1:0]  r_count,  n_count;

    logic            w_accept;
    logic            w_pop;
    logic [RxW-1:0]  w_byte;
    logic            w_is_payload;
    logic            w_is_id;
    logic [2:0]      w_id_sel;
    logic [RxW-1:0]  w_id_want;
    logic [PosW-1:0] w_pos_inc;
    t_verdict        w_verdict;
    t_result         w_res_pay;
    t_result         w_res_verd;
    t_result         w_head;
    logic [1:0]      w_push_cnt;

    assign w_byte   = s_axis_tdata;
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_pop    = m_axis_tvalid && m_axis_tready;

    // keep room for the worst case of two results per request
    assign s_axis_tready = (r_count <= QCntW'(QDepth - 2));

    // identifier byte at position p is card_id byte (9 - p); p = 2 hits bits 63:56
    assign w_is_id   = (r_pos >= IdFirstPos) && (r_pos <= IdLastPos);
    assign w_id_sel  = 3'(4'd9 - r_pos[3:0]);
    assign w_id_want = r_card_id[{w_id_sel, 3'b000} +: RxW];

    assign w_is_payload = (r_pos >= PayloadPos);
    assign w_pos_inc    = (r_pos < PosMax) ? r_pos + 9'd1 : r_pos;

    // updated frame fields as seen by this byte (verdict uses them directly)
    logic [RxW-1:0] w_len;
    logic           w_code_ok;
    logic           w_id_ok;
    logic [RxW-1:0] w_flag1;
    logic [RxW-1:0] w_flag2;

    always_comb begin
        w_len     = (r_pos == LenPos)   ? w_byte : r_len;
        w_code_ok = (r_pos == CodePos)  ? (w_byte == RespCode) : r_code_ok;
        w_id_ok   = r_id_ok && !(w_is_id && (w_byte != w_id_want));
        w_flag1   = (r_pos == Flag1Pos) ? w_byte : r_flag1;
        w_flag2   = (r_pos == Flag2Pos) ? w_byte : r_flag2;
    end

    // first failing test wins; a saturated count of 256 never matches an 8-bit length
    always_comb begin
        if (w_pos_inc < HeaderLen) begin
            w_verdict = VERDICT_TOO_SHORT;
        end else if (w_pos_inc != {1'b0, w_len}) begin
            w_verdict = VERDICT_LEN_MISM;
        end else if (!w_code_ok) begin
            w_verdict = VERDICT_BAD_CODE;
        end else if (!w_id_ok) begin
            w_verdict = VERDICT_ID_MISM;
        end else if ((w_flag1 != '0) || (w_flag2 != '0)) begin
            w_verdict = VERDICT_CARD_ERROR;
        end else begin
            w_verdict = VERDICT_OK;
        end
    end

    always_comb begin
        w_res_pay         = '0;
        w_res_pay.kind    = KIND_PAYLOAD;
        w_res_pay.payload = w_byte;
        w_res_verd         = '0;
        w_res_verd.kind    = KIND_VERDICT;
        w_res_verd.verdict = w_verdict;
        w_res_verd.flag1   = w_flag1;
        w_res_verd.flag2   = w_flag2;
        w_res_verd.last    = 1'b1;
    end

    // frame state next values; end of frame returns to the cleared state
    always_comb begin
        n_pos     = r_pos;
        n_len     = r_len;
        n_code_ok = r_code_ok;
        n_id_ok   = r_id_ok;
        n_flag1   = r_flag1;
        n_flag2   = r_flag2;
        if (w_accept) begin
            if (s_axis_tlast) begin
                n_pos     = '0;
                n_len     = '0;
                n_code_ok = 1'b0;
                n_id_ok   = 1'b1;
                n_flag1   = '0;
                n_flag2   = '0;
            end else begin
                n_pos     = w_pos_inc;
                n_len     = w_len;
                n_code_ok = w_code_ok;
                n_id_ok   = w_id_ok;
                n_flag1   = w_flag1;
                n_flag2   = w_flag2;
            end
        end
    end

    // queue pointers: payload (if any) goes in first, verdict after it
    always_comb begin
        w_push_cnt = 2'd0;
        if (w_accept) begin
            w_push_cnt = 2'({1'b0, w_is_payload} + {1'b0, s_axis_tlast});
        end
        n_wr_ptr = r_wr_ptr + QPtrW'(w_push_cnt);
        n_rd_ptr = w_pop ? r_rd_ptr + QPtrW'(1) : r_rd_ptr;
        n_count  = r_count + QCntW'(w_push_cnt) - QCntW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_card_id <= '0;
            r_pos     <= '0;
            r_len     <= '0;
            r_code_ok <= 1'b0;
            r_id_ok   <= 1'b1;
            r_flag1   <= '0;
            r_flag2   <= '0;
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_count   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_card_id <= i_cfg_wr_data;
            end
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_code_ok <= n_code_ok;
            r_id_ok   <= n_id_ok;
            r_flag1   <= n_flag1;
            r_flag2   <= n_flag2;
            r_wr_ptr  <= n_wr_ptr;
            r_rd_ptr  <= n_rd_ptr;
            r_count   <= n_count;
        end
    end

    // queue storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (w_is_payload) begin
                r_queue[r_wr_ptr] <= w_res_pay;
                if (s_axis_tlast) begin
                    r_queue[r_wr_ptr + QPtrW'(1)] <= w_res_verd;
                end
            end else if (s_axis_tlast) begin
                r_queue[r_wr_ptr] <= w_res_verd;
            end
        end
    end

    assign w_head        = r_queue[r_rd_ptr];
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = {{PadW{1'b0}}, w_head.flag2, w_head.flag1,
                            w_head.verdict, w_head.payload};
    assign m_axis_tuser  = w_head.kind;
    assign m_axis_tlast  = w_head.last;

endmodule
